FILE: sv/assert_macros.svh
// Assertion macros shared by the guillotine waste RTL.
// Uses clk and arst_n of the including module; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GMW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GMW_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define GMW_ASSERT(lbl, prop, msg)
`define GMW_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: sv/gmw_pkg.sv
// Shared constants and control structs for the guillotine waste block.
// No dependencies.
`timescale 1ns / 1ps
package gmw_pkg;
	localparam int MAX_DIM_DEF = 64;
	localparam int SIZE_W      = 7;
	localparam int WASTE_W     = 13;
	localparam logic [WASTE_W-1:0] WASTE_MAX = 13'd8191;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_bit;
	} gmw_pmap_ctl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} gmw_wtab_ctl_t;

	typedef struct packed {
		logic valid;
		logic is_answer;
	} gmw_res_t;
endpackage

FILE: sv/gmw_pmap.sv
// Allowed-piece bitmap: one-bit synchronous memory with a clearing pass after reset.
// Depends on gmw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmw_pmap import gmw_pkg::*; #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gmw_pmap_ctl_t ctl,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_bit,
	output logic          clr_busy
);
	logic          mem [2**AW];
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	// sweep every entry to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q)
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_cnt_q] <= 1'b0;
		else if (ctl.wr_en)
			mem[wr_addr] <= ctl.wr_bit;
		if (ctl.rd_en)
			rd_bit <= mem[rd_addr];
	end

	assign clr_busy = clr_q;

	`GMW_ASSERT_NEVER(a_no_wr_in_clear, clr_q && ctl.wr_en, "piece write during clearing pass")
	`GMW_ASSERT_NEVER(a_no_rd_in_clear, clr_q && ctl.rd_en, "piece read during clearing pass")
	`GMW_ASSERT(a_clear_ends, clr_q && (&clr_cnt_q) |=> !clr_q, "clearing pass overran")
endmodule

FILE: sv/gmw_wtab.sv
// Waste table: synchronous memory, one write port and two read ports.
// Depends on gmw_pkg.
`timescale 1ns / 1ps
module gmw_wtab import gmw_pkg::*; #(
	parameter int AW = 12,
	parameter int VW = 13
) (
	input  logic          clk,
	input  gmw_wtab_ctl_t ctl,
	input  logic [AW-1:0] wr_addr,
	input  logic [VW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [VW-1:0] rd_data_a,
	output logic [VW-1:0] rd_data_b
);
	logic [VW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem[wr_addr] <= wr_data;
		if (ctl.rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end
endmodule

FILE: sv/gmw_ctrl.sv
// Sequencer for the bottom-up waste fill: walks cells, scans cuts, writes back.
// Depends on gmw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmw_ctrl import gmw_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int DW = 7,
	parameter int IW = 6,
	parameter int AW = 12,
	parameter int VW = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  logic [SIZE_W-1:0]   in_width,
	input  logic [SIZE_W-1:0]   in_length,
	input  logic                in_allowed,
	input  logic                clr_busy,
	output gmw_pmap_ctl_t       pm_ctl,
	output logic [AW-1:0]       pm_wr_addr,
	output logic [AW-1:0]       pm_rd_addr,
	input  logic                pm_rd_bit,
	output gmw_wtab_ctl_t       wt_ctl,
	output logic [AW-1:0]       wt_wr_addr,
	output logic [VW-1:0]       wt_wr_data,
	output logic [AW-1:0]       wt_rd_addr_a,
	output logic [AW-1:0]       wt_rd_addr_b,
	input  logic [VW-1:0]       wt_rd_data_a,
	input  logic [VW-1:0]       wt_rd_data_b,
	output gmw_res_t            res,
	output logic [VW-1:0]       res_waste,
	input  logic                res_ready
);
	localparam int CW = (DW > SIZE_W) ? DW : SIZE_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CELL  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_CUT   = 7'b0001000,
		S_DRAIN = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_DONE  = 7'b1000000
	} gmw_state_t;

	gmw_state_t    state_q;
	logic [DW-1:0] w_q, l_q, wq_q, lq_q, k_q;
	logic          cut_len_q;
	logic          ans_q;
	logic          rd_v_s1;
	logic [VW-1:0] best_q, area_q;

	logic [CW-1:0] w_ext, l_ext;
	logic [DW-1:0] w_sat, l_sat, half_w, half_l;
	logic          wr_in_range;
	logic [VW:0]   sum;
	logic          accept;

	function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] w, input logic [DW-1:0] l);
		logic [DW-1:0] wm, lm;
		wm = w - DW'(1);
		lm = l - DW'(1);
		return {wm[IW-1:0], lm[IW-1:0]};
	endfunction

	assign w_ext = CW'(in_width);
	assign l_ext = CW'(in_length);
	assign w_sat = (w_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(w_ext);
	assign l_sat = (l_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(l_ext);
	assign wr_in_range = (w_ext != '0) && (l_ext != '0) &&
		(w_ext <= CW'(MAX_DIM)) && (l_ext <= CW'(MAX_DIM));

	assign half_w = w_q >> 1;
	assign half_l = l_q >> 1;
	assign sum    = {1'b0, wt_rd_data_a} + {1'b0, wt_rd_data_b};

	assign in_ready = (state_q == S_IDLE) && !clr_busy;
	assign accept   = in_valid && in_ready;

	// piece map: user writes at accept, DP read at cell start
	assign pm_ctl.wr_en  = accept && (in_mode == MODE_WRITE) && wr_in_range;
	assign pm_ctl.wr_bit = in_allowed;
	assign pm_ctl.rd_en  = (state_q == S_CELL);
	assign pm_wr_addr    = cell_addr(w_sat, l_sat);
	assign pm_rd_addr    = cell_addr(w_q, l_q);

	// cut reads: across width (w-k,l)+(k,l), across length (w,l-k)+(w,k)
	assign wt_ctl.rd_en  = (state_q == S_CUT);
	assign wt_ctl.wr_en  = (state_q == S_WRITE);
	assign wt_rd_addr_a  = cut_len_q ? cell_addr(w_q, l_q - k_q) : cell_addr(w_q - k_q, l_q);
	assign wt_rd_addr_b  = cut_len_q ? cell_addr(w_q, k_q) : cell_addr(k_q, l_q);
	assign wt_wr_addr    = cell_addr(w_q, l_q);
	assign wt_wr_data    = best_q;

	assign res.valid     = (state_q == S_DONE);
	assign res.is_answer = ans_q;
	assign res_waste     = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_v_s1   <= 1'b0;
			w_q       <= '0;
			l_q       <= '0;
			wq_q      <= '0;
			lq_q      <= '0;
			k_q       <= '0;
			cut_len_q <= 1'b0;
			ans_q     <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_CUT);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ans_q <= (in_mode == MODE_QUERY);
						wq_q  <= w_sat;
						lq_q  <= l_sat;
						w_q   <= DW'(1);
						l_q   <= DW'(1);
						if (in_mode == MODE_QUERY && w_sat != '0 && l_sat != '0)
							state_q <= S_CELL;
						else
							state_q <= S_DONE;
					end
				end
				S_CELL: state_q <= S_CHECK;
				S_CHECK: begin
					k_q <= DW'(1);
					cut_len_q <= (half_w == '0);
					if (pm_rd_bit || (half_w == '0 && half_l == '0))
						state_q <= S_WRITE;
					else
						state_q <= S_CUT;
				end
				S_CUT: begin
					if (!cut_len_q && k_q == half_w) begin
						if (half_l != '0) begin
							cut_len_q <= 1'b1;
							k_q       <= DW'(1);
						end else begin
							state_q <= S_DRAIN;
						end
					end else if (cut_len_q && k_q == half_l) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_WRITE;
				S_WRITE: begin
					if (l_q == lq_q) begin
						l_q <= DW'(1);
						if (w_q == wq_q)
							state_q <= S_DONE;
						else begin
							w_q     <= w_q + 1'b1;
							state_q <= S_CELL;
						end
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_CELL;
					end
				end
				S_DONE: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: area, running minimum
	always_ff @(posedge clk) begin
		if (state_q == S_CELL)
			area_q <= VW'(w_q) * VW'(l_q);
		if (accept)
			best_q <= '0;
		else if (state_q == S_CHECK)
			best_q <= pm_rd_bit ? '0 : area_q;
		else if (rd_v_s1 && (sum < {1'b0, best_q}))
			best_q <= best_q - VW'({1'b0, best_q} - sum);
	end

	`GMW_ASSERT_NEVER(a_wt_rw_excl, wt_ctl.wr_en && wt_ctl.rd_en, "table write overlaps cut read")
	`GMW_ASSERT(a_best_falls, rd_v_s1 |=> best_q <= $past(best_q), "running minimum rose")
	`GMW_ASSERT(a_write_ack_zero, res.valid && !res.is_answer |-> best_q == '0,
		"write acknowledge with nonzero waste")
	`GMW_ASSERT(a_cut_range, state_q == S_CUT && !cut_len_q |-> k_q != '0 && k_q <= half_w,
		"cut position out of range")
endmodule

FILE: sv/guillotine_min_waste_dp.sv
// Guillotine cutting, minimum waste.
// Input stream (s_*): one transfer per item. s_tuser is the kind: 0 writes the
// allowed flag of one piece size, 1 queries a field size. Output stream (m_*):
// exactly one transfer per input item; m_tuser is 1 for a query answer (m_tdata
// holds the waste) and 0 for a write acknowledge (m_tdata zero).
// A query fills the waste table bottom-up over every w x l up to the field
// size. An allowed piece or a 1x1 cell passes the cell, check and write states;
// any other cell scans cuts 1..floor(w/2) across the width and 1..floor(l/2)
// across the length, one cut position per cycle, both halves read through the
// two read ports of the table memory, then drains and writes. A write or a
// zero-sized query skips the fill. One item is in flight at a time.
// After reset the piece bitmap is swept to zero, one entry per cycle;
// s_tready stays low during that pass.
// Results wait in an output register; while the receiver stalls, the next
// item is still taken and worked on, and it holds at its end until the
// register frees.
// Depends on gmw_pkg, gmw_pmap, gmw_wtab, gmw_ctrl.
`timescale 1ns / 1ps
module guillotine_min_waste_dp import gmw_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [6:0] size_width, [13:7] size_length, [14] allowed, [15] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] mode
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [12:0] waste, [15:13] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// [0] is_answer
	output logic                   m_tuser
);
	localparam int DW = $clog2(MAX_DIM + 1);     // holds a side up to MAX_DIM
	localparam int IW = $clog2(MAX_DIM);         // index of one side
	localparam int AW = 2 * IW;                  // table address {w-1, l-1}
	localparam int VW = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int EW = (VW > WASTE_W) ? VW : WASTE_W;

	gmw_pmap_ctl_t pm_ctl;
	gmw_wtab_ctl_t wt_ctl;
	gmw_res_t      res;
	logic [AW-1:0] pm_wr_addr, pm_rd_addr, wt_wr_addr, wt_rd_addr_a, wt_rd_addr_b;
	logic [VW-1:0] wt_wr_data, wt_rd_data_a, wt_rd_data_b, res_waste;
	logic          pm_rd_bit, clr_busy, res_ready;
	logic [EW-1:0] waste_ext;
	logic [WASTE_W-1:0] waste_sat;

	logic               m_valid_q;
	logic [WASTE_W-1:0] m_waste_q;
	logic               m_ans_q;

	gmw_pmap #(.AW(AW)) u_pmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pm_ctl),
		.wr_addr  (pm_wr_addr),
		.rd_addr  (pm_rd_addr),
		.rd_bit   (pm_rd_bit),
		.clr_busy (clr_busy)
	);

	gmw_wtab #(.AW(AW), .VW(VW)) u_wtab (
		.clk       (clk),
		.ctl       (wt_ctl),
		.wr_addr   (wt_wr_addr),
		.wr_data   (wt_wr_data),
		.rd_addr_a (wt_rd_addr_a),
		.rd_addr_b (wt_rd_addr_b),
		.rd_data_a (wt_rd_data_a),
		.rd_data_b (wt_rd_data_b)
	);

	gmw_ctrl #(
		.MAX_DIM (MAX_DIM),
		.DW      (DW),
		.IW      (IW),
		.AW      (AW),
		.VW      (VW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_mode      (s_tuser),
		.in_width     (s_tdata[SIZE_W-1:0]),
		.in_length    (s_tdata[2*SIZE_W-1:SIZE_W]),
		.in_allowed   (s_tdata[2*SIZE_W]),
		.clr_busy     (clr_busy),
		.pm_ctl       (pm_ctl),
		.pm_wr_addr   (pm_wr_addr),
		.pm_rd_addr   (pm_rd_addr),
		.pm_rd_bit    (pm_rd_bit),
		.wt_ctl       (wt_ctl),
		.wt_wr_addr   (wt_wr_addr),
		.wt_wr_data   (wt_wr_data),
		.wt_rd_addr_a (wt_rd_addr_a),
		.wt_rd_addr_b (wt_rd_addr_b),
		.wt_rd_data_a (wt_rd_data_a),
		.wt_rd_data_b (wt_rd_data_b),
		.res          (res),
		.res_waste    (res_waste),
		.res_ready    (res_ready)
	);

	// clamp to the 13-bit result field (only bites above MAX_DIM 90)
	assign waste_ext = EW'(res_waste);
	assign waste_sat = (waste_ext > EW'(WASTE_MAX)) ? WASTE_MAX : waste_ext[WASTE_W-1:0];

	// output register; frees in the same cycle it is taken
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (res_ready)
			m_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			m_waste_q <= waste_sat;
			m_ans_q   <= res.is_answer;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(m_waste_q);
	assign m_tuser  = m_ans_q;
endmodule

FILE: sim/tb_guillotine_min_waste_dp.sv
// Self-checking bench for guillotine_min_waste_dp: piece writes and waste queries
// checked against a bit-true waste predictor. Depends on gmw_pkg and the RTL.
`timescale 1ns / 1ps
module tb_guillotine_min_waste_dp;
	import gmw_pkg::*;

	localparam int DIM = MAX_DIM_DEF;
	localparam int N_RANDOM = 76;

	typedef struct packed {
		logic               mode;
		logic [SIZE_W-1:0]  wid;
		logic [SIZE_W-1:0]  len;
		logic               allowed;
	} cut_req_t;

	typedef struct packed {
		logic [WASTE_W-1:0] waste;
		logic               is_answer;
	} cut_resp_t;

	// typed = 1: resp is the expectation, read straight off the spec
	typedef struct packed {
		cut_req_t  req;
		logic      typed;
		cut_resp_t resp;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	// predictor state
	bit piece_ok [DIM][DIM];
	int waste_grid [DIM][DIM];

	cut_resp_t awaited_resp [$];
	dir_row_t  dir_rows [$];

	int send_idle_pct = 16;
	int recv_idle_pct = 68;
	int err_count = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_checked = 0;

	guillotine_min_waste_dp uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Bottom-up waste fill, same order as the block; writes update the bitmap.
	function automatic cut_resp_t predict_resp(input cut_req_t req);
		cut_resp_t r;
		int w, l, a, b, k, best, s;
		r = '0;
		w = int'(req.wid);
		l = int'(req.len);
		if (req.mode == MODE_WRITE) begin
			if (w >= 1 && w <= DIM && l >= 1 && l <= DIM)
				piece_ok[w-1][l-1] = req.allowed;
			return r;
		end
		if (w > DIM) w = DIM;
		if (l > DIM) l = DIM;
		best = 0;
		if (w != 0 && l != 0) begin
			for (a = 1; a <= w; a++) begin
				for (b = 1; b <= l; b++) begin
					if (piece_ok[a-1][b-1]) begin
						best = 0;
					end else begin
						best = a * b;
						for (k = 1; k <= a / 2; k++) begin
							s = waste_grid[a-k-1][b-1] + waste_grid[k-1][b-1];
							if (s < best) best = s;
						end
						for (k = 1; k <= b / 2; k++) begin
							s = waste_grid[a-1][b-k-1] + waste_grid[a-1][k-1];
							if (s < best) best = s;
						end
					end
					waste_grid[a-1][b-1] = best;
				end
			end
			best = waste_grid[w-1][l-1];
		end
		if (best > int'(WASTE_MAX)) best = int'(WASTE_MAX);
		r.waste = WASTE_W'(best);
		r.is_answer = 1'b1;
		return r;
	endfunction

	task automatic add_row(input logic mode, input int w, input int l, input logic allowed,
			input logic typed, input int waste, input logic is_answer);
		dir_row_t row;
		row.req.mode = mode;
		row.req.wid = SIZE_W'(w);
		row.req.len = SIZE_W'(l);
		row.req.allowed = allowed;
		row.typed = typed;
		row.resp.waste = WASTE_W'(waste);
		row.resp.is_answer = is_answer;
		dir_rows.push_back(row);
	endtask

	// Entered right after a falling edge; returns right after a falling edge, once the transfer is taken.
	task automatic push_item(input cut_req_t req, input logic typed, input cut_resp_t typed_resp);
		cut_resp_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			s_tuser <= 1'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, req.allowed, req.len, req.wid};
		s_tuser <= req.mode;
		do @(posedge clk); while (!s_tready);
		// transfer taken: predictor always runs so the bitmap tracks writes
		r = predict_resp(req);
		awaited_resp.push_back(typed ? typed_resp : r);
		if (req.mode == MODE_WRITE) n_writes++;
		else n_queries++;
		@(negedge clk);
	endtask

	// receiver stalls at random
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// result checker
	always @(posedge clk) begin
		cut_resp_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_resp.size() == 0) begin
				$error("result with nothing pending: waste=%0d is_answer=%0b",
					m_tdata[WASTE_W-1:0], m_tuser);
				err_count++;
			end else begin
				exp_r = awaited_resp.pop_front();
				n_checked++;
				if (m_tdata[WASTE_W-1:0] !== exp_r.waste) begin
					$error("waste: expected %0d, got %0d", exp_r.waste, m_tdata[WASTE_W-1:0]);
					err_count++;
				end
				if (m_tuser !== exp_r.is_answer) begin
					$error("is_answer: expected %0b, got %0b", exp_r.is_answer, m_tuser);
					err_count++;
				end
			end
		end
	end

	initial begin
		cut_req_t  req;
		cut_resp_t none;
		int i, pick, w, l;
		none = '0;

		// after reset nothing is allowed, so waste equals area
		add_row(MODE_QUERY, 1, 1, 1'b0, 1'b1, 1, 1'b1);
		add_row(MODE_QUERY, 0, 5, 1'b1, 1'b1, 0, 1'b1);
		add_row(MODE_QUERY, 5, 0, 1'b0, 1'b1, 0, 1'b1);
		add_row(MODE_QUERY, 0, 0, 1'b0, 1'b1, 0, 1'b1);
		add_row(MODE_QUERY, 64, 64, 1'b0, 1'b1, 4096, 1'b1);
		// out-of-range writes: acked, bitmap untouched
		add_row(MODE_WRITE, 0, 5, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_WRITE, 65, 5, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_WRITE, 5, 127, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 5, 5, 1'b0, 1'b0, 0, 1'b0);
		add_row(MODE_WRITE, 3, 2, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 3, 2, 1'b0, 1'b1, 0, 1'b1);
		add_row(MODE_QUERY, 6, 2, 1'b0, 1'b0, 0, 1'b0);
		add_row(MODE_QUERY, 7, 5, 1'b1, 1'b0, 0, 1'b0);
		// full-size piece; oversized query saturates onto it
		add_row(MODE_WRITE, 64, 64, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 127, 127, 1'b0, 1'b1, 0, 1'b1);
		add_row(MODE_WRITE, 64, 64, 1'b0, 1'b1, 0, 1'b0);
		add_row(MODE_WRITE, 1, 64, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 3, 127, 1'b0, 1'b0, 0, 1'b0);
		add_row(MODE_QUERY, 127, 3, 1'b1, 1'b0, 0, 1'b0);
		add_row(MODE_WRITE, 2, 3, 1'b1, 1'b1, 0, 1'b0);
		add_row(MODE_WRITE, 5, 7, 1'b0, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 10, 10, 1'b0, 1'b0, 0, 1'b0);
		add_row(MODE_WRITE, 3, 2, 1'b0, 1'b1, 0, 1'b0);
		add_row(MODE_QUERY, 10, 10, 1'b0, 1'b0, 0, 1'b0);

		// single reset at start; block then sweeps its bitmap with s_tready low
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[j])
			push_item(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].resp);

		for (i = 0; i < N_RANDOM; i++) begin
			// idling phases: slow receiver, then slow sender, then full rate
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 68;
				recv_idle_pct = 16;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(99);
			if ($urandom_range(99) < 55) begin
				req.mode = MODE_WRITE;
				if (pick < 70) begin
					w = $urandom_range(16, 1);
					l = $urandom_range(16, 1);
				end else if (pick < 85) begin
					w = $urandom_range(DIM, 1);
					l = $urandom_range(DIM, 1);
				end else begin
					w = $urandom_range(127);
					l = $urandom_range(127);
				end
				req.allowed = ($urandom_range(99) < 65);
			end else begin
				req.mode = MODE_QUERY;
				req.allowed = 1'($urandom);
				if (pick < 85) begin
					w = $urandom_range(16, 1);
					l = $urandom_range(16, 1);
				end else if (pick < 93) begin
					w = $urandom_range(32, 1);
					l = $urandom_range(32, 1);
				end else if (pick < 97) begin
					// one side anywhere, incl. zero and saturating; keep the other short
					w = $urandom_range(127);
					l = $urandom_range(4);
				end else begin
					w = $urandom_range(4);
					l = $urandom_range(127);
				end
			end
			req.wid = SIZE_W'(w);
			req.len = SIZE_W'(l);
			push_item(req, 1'b0, none);
		end
		s_tvalid <= 1'b0;

		while (awaited_resp.size() != 0) @(posedge clk);
		// keep clocking to catch any stray result
		repeat (40) @(posedge clk);

		$display("Run covered %0d piece writes and %0d field queries; %0d results checked",
			n_writes, n_queries, n_checked);
		$display("Directed extremes and out-of-range cases, then random traffic in three stall mixes");
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
